// File: src/slg_pkg.sv
// Shared types, constants and elaboration-time table builders for the sRGB lightness gray block.
package slg_pkg;

	// Width of the gray result and of the threshold search index.
	localparam int unsigned GrayW = 8;

	// Number of entries in every lookup table (one per 8-bit code or gray level).
	localparam int unsigned TblDepth = 256;

	// Fixed-point format used while the tables are built.
	localparam int unsigned Q30Bits = 30;
	localparam longint unsigned Q30One = 64'd1 << Q30Bits;

	// Table entries are held at a fixed width and narrowed where they are read.
	typedef logic [31:0] word_tbl_t [TblDepth];

	// Control that travels with a luminance beat into the lightness search.
	typedef struct packed {
		logic vld;
		logic dark;
	} srch_ctl_t;

	// Power of a Q0.30 value, each step truncated.
	function automatic longint unsigned q30_pow(longint unsigned r, int unsigned n);
		longint unsigned acc;
		acc = Q30One;
		for (int unsigned i = 0; i < n; i++) begin
			acc = (acc * r) >> Q30Bits;
		end
		return acc;
	endfunction

	// Largest Q0.30 value whose truncated n-th power does not exceed the target.
	function automatic longint unsigned q30_root(longint unsigned target, int unsigned n);
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned mid;
		lo = 0;
		hi = Q30One;
		for (int unsigned i = 0; i < 32; i++) begin
			if (lo < hi) begin
				mid = (lo + hi + 1) >> 1;
				if (q30_pow(mid, n) <= target) begin
					lo = mid;
				end else begin
					hi = mid - 1;
				end
			end
		end
		return lo;
	endfunction

	// sRGB code to linear light in Q1.f, one entry per code.
	function automatic word_tbl_t lin_table(int unsigned f);
		word_tbl_t tbl;
		longint unsigned c;
		longint unsigned x;
		longint unsigned s;
		longint unsigned r;
		longint unsigned y;
		for (int unsigned code = 0; code < TblDepth; code++) begin
			c = longint'(code);
			if (code <= 10) begin
				tbl[code] = 32'((c * 10 * (64'd1 << f) + 16473) / 32946);
			end else begin
				x = ((1000 * c + 14025) << Q30Bits) / 269025;
				s = (x * x) >> Q30Bits;
				r = q30_root(s, 5);
				y = (s * r) >> Q30Bits;
				tbl[code] = 32'((y + (64'd1 << (Q30Bits - 1 - f))) >> (Q30Bits - f));
			end
		end
		return tbl;
	endfunction

	// Smallest luminance whose dark-segment gray reaches each level.
	// Gray = floor(lum * 6219195 / (2700 * 2^f)), so the bound is a ceiling division.
	function automatic word_tbl_t dark_table(int unsigned f);
		word_tbl_t tbl;
		longint unsigned num;
		for (int unsigned g = 0; g < TblDepth; g++) begin
			num = longint'(g) * 2700 * (64'd1 << f);
			tbl[g] = 32'((num + 6219194) / 6219195);
		end
		return tbl;
	endfunction

	// Smallest luminance whose cube-root-segment gray reaches each level.
	// The level needs a root of at least qmin; the root reaches qmin exactly when
	// the truncated cube of qmin fits under the scaled luminance.
	function automatic word_tbl_t cube_table(int unsigned f);
		word_tbl_t tbl;
		longint unsigned qmin;
		longint unsigned cube;
		longint unsigned step;
		step = 64'd1 << (Q30Bits - f);
		tbl[0] = '0;
		for (int unsigned g = 1; g < TblDepth; g++) begin
			qmin = ((408 + 10 * longint'(g)) * Q30One + 2957) / 2958;
			if (qmin > Q30One) begin
				tbl[g] = '1;
			end else begin
				// The step is a power of two, so the ceiling is a rounded-up shift.
				cube = q30_pow(qmin, 3);
				tbl[g] = 32'((cube + step - 1) >> (Q30Bits - f));
			end
		end
		return tbl;
	endfunction

endpackage

// File: src/slg_lstar_search.sv
// Pipelined binary search of luminance against the lightness threshold tables.
module slg_lstar_search #(
	parameter int unsigned LIN_FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  slg_pkg::srch_ctl_t            in_ctl,
	input  logic [LIN_FRAC_BITS:0]        in_lum,
	output logic                          out_vld,
	output logic [slg_pkg::GrayW-1:0]     out_gray
);

	localparam int unsigned LumW   = LIN_FRAC_BITS + 1;
	localparam int unsigned Stages = slg_pkg::GrayW;

	localparam slg_pkg::word_tbl_t TDark = slg_pkg::dark_table(LIN_FRAC_BITS);
	localparam slg_pkg::word_tbl_t TCube = slg_pkg::cube_table(LIN_FRAC_BITS);

	// One register set per search step; lum and dark are not needed after the last.
	logic                          step_vld_s  [Stages];
	logic [slg_pkg::GrayW-1:0]     step_idx_s  [Stages];
	logic [LumW-1:0]               step_lum_s  [Stages-1];
	logic                          step_dark_s [Stages-1];

	for (genvar k = 0; k < Stages; k++) begin : g_step
		localparam logic [slg_pkg::GrayW-1:0] StepBit = slg_pkg::GrayW'(2 ** (Stages - 1 - k));

		logic                      vld_prev;
		logic [slg_pkg::GrayW-1:0] idx_prev;
		logic [LumW-1:0]           lum_prev;
		logic                      dark_prev;
		logic [slg_pkg::GrayW-1:0] cand;
		logic [31:0]               thr;
		logic                      take;

		if (k == 0) begin : g_first
			assign vld_prev  = in_ctl.vld;
			assign idx_prev  = '0;
			assign lum_prev  = in_lum;
			assign dark_prev = in_ctl.dark;
		end else begin : g_next
			assign vld_prev  = step_vld_s[k-1];
			assign idx_prev  = step_idx_s[k-1];
			assign lum_prev  = step_lum_s[k-1];
			assign dark_prev = step_dark_s[k-1];
		end

		// Try the next bit of the level: keep it when its threshold is reached.
		always_comb begin
			cand = idx_prev | StepBit;
			thr  = dark_prev ? TDark[cand] : TCube[cand];
			take = (thr[LumW-1:0] <= lum_prev);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				step_vld_s[k] <= 1'b0;
			end else begin
				step_vld_s[k] <= vld_prev;
			end
		end

		always_ff @(posedge clk) begin
			step_idx_s[k] <= take ? cand : idx_prev;
		end

		if (k < Stages - 1) begin : g_carry
			always_ff @(posedge clk) begin
				step_lum_s[k]  <= lum_prev;
				step_dark_s[k] <= dark_prev;
			end
		end
	end

	assign out_vld  = step_vld_s[Stages-1];
	assign out_gray = step_idx_s[Stages-1];

endmodule

// File: src/srgb_to_lightness_gray.sv
// Top level: sRGB pixel to CIE lightness gray value, fully pipelined.
//
//  channel | dir | handshake                    | fields
//  --------+-----+------------------------------+-------------------
//  pixel   | in  | start, busy (beat: start&!busy) | red, green, blue
//  result  | out | done (one-cycle strobe)      | gray
//
// One pixel beat can be taken on every clock while busy is low; each beat produces
// exactly one result beat after 3 arithmetic stages plus 8 search stages.
// The 8-step threshold search finds one gray bit per stage.
// Reset is asynchronous and active low; it empties the pipeline and holds busy
// high until the first clock edge after reset is released.
// The receiver cannot stall: done is a strobe, and the pipeline never holds.
module srgb_to_lightness_gray #(
	parameter int unsigned LIN_FRAC_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	output logic       done,
	output logic [7:0] gray
);

	// Linear light is Q1.F (white is exactly 1.0), the weights are Q0.F.
	localparam int unsigned LinW  = LIN_FRAC_BITS + 1;
	localparam int unsigned WgtW  = LIN_FRAC_BITS;
	localparam int unsigned ProdW = WgtW + LinW;
	localparam int unsigned LumW  = LIN_FRAC_BITS + 1;

	localparam longint unsigned One      = 64'd1 << LIN_FRAC_BITS;
	localparam longint unsigned WeightR64 = (2126 * One * 2 + 10000) / 20000;
	localparam longint unsigned WeightB64 = (722 * One * 2 + 10000) / 20000;
	localparam longint unsigned WeightG64 = One - WeightR64 - WeightB64;
	localparam longint unsigned DarkMax64 = (216 * One) / 24389;

	localparam logic [WgtW-1:0]  WeightR = WgtW'(WeightR64);
	localparam logic [WgtW-1:0]  WeightG = WgtW'(WeightG64);
	localparam logic [WgtW-1:0]  WeightB = WgtW'(WeightB64);
	localparam logic [ProdW-1:0] RoundHalf = ProdW'(One >> 1);
	localparam logic [LumW-1:0]  DarkMax = LumW'(DarkMax64);

	// Transfer curve table, one entry per 8-bit code.
	localparam slg_pkg::word_tbl_t LinTbl = slg_pkg::lin_table(LIN_FRAC_BITS);

	logic busy_q;
	logic accept;

	logic            vld_s1;
	logic [LinW-1:0] lin_r_s1;
	logic [LinW-1:0] lin_g_s1;
	logic [LinW-1:0] lin_b_s1;

	logic             vld_s2;
	logic [ProdW-1:0] prod_r_s2;
	logic [ProdW-1:0] prod_g_s2;
	logic [ProdW-1:0] prod_b_s2;

	logic [ProdW-1:0] lum_sum;
	logic [LumW-1:0]  lum_c;

	slg_pkg::srch_ctl_t ctl_s3;
	logic [LumW-1:0]    lum_s3;

	// Busy only marks the cycles of reset; afterwards a beat can enter every clock.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy   = busy_q;
	assign accept = start & ~busy_q;

	// Stage 1: each channel is linearized through the constant table.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lin_r_s1 <= LinTbl[red][LinW-1:0];
			lin_g_s1 <= LinTbl[green][LinW-1:0];
			lin_b_s1 <= LinTbl[blue][LinW-1:0];
		end
	end

	// Stage 2: one weight multiplier per channel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_r_s2 <= ProdW'(WeightR) * ProdW'(lin_r_s1);
		prod_g_s2 <= ProdW'(WeightG) * ProdW'(lin_g_s1);
		prod_b_s2 <= ProdW'(WeightB) * ProdW'(lin_b_s1);
	end

	// Stage 3: the weights sum to exactly one, so the rounded sum never
	// exceeds white and fits the product width; Y is its upper bits.
	always_comb begin
		lum_sum = prod_r_s2 + prod_g_s2 + prod_b_s2 + RoundHalf;
		lum_c   = lum_sum[ProdW-1 -: LumW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else begin
			ctl_s3.vld  <= vld_s2;
			ctl_s3.dark <= (lum_c <= DarkMax);
		end
	end

	always_ff @(posedge clk) begin
		lum_s3 <= lum_c;
	end

	// Stages 4 to 11: the gray level is the count of thresholds that Y reaches,
	// found one bit per stage. At or below the dark limit the linear segment's
	// thresholds apply, above it those of the cube-root segment. The last
	// search register is the result register.
	slg_lstar_search #(
		.LIN_FRAC_BITS(LIN_FRAC_BITS)
	) u_search (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ctl  (ctl_s3),
		.in_lum  (lum_s3),
		.out_vld (done),
		.out_gray(gray)
	);

endmodule

// File: src/slg_checker.sv
// Port-level checker for the lightness gray block, bound to the top level.
module slg_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [7:0] red,
	input logic [7:0] green,
	input logic [7:0] blue,
	input logic       done,
	input logic [7:0] gray
);

	localparam int unsigned Latency = 11;

	// Once busy drops after reset it stays low.
	a_busy_stays_low: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> !busy)
		else $error("busy rose again after reset");

	// Every accepted beat yields a result once it has passed through the pipeline.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##Latency done)
		else $error("accepted pixel produced no result");

	// No result appears without an accepted beat before it.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, Latency))
		else $error("result without a matching pixel");

	// Black maps to zero and white to full scale.
	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && red == 8'd0 && green == 8'd0 && blue == 8'd0)
		|-> ##Latency (gray == 8'd0))
		else $error("black pixel did not give zero");

	a_white: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && red == 8'd255 && green == 8'd255 && blue == 8'd255)
		|-> ##Latency (gray == 8'd255))
		else $error("white pixel did not give full scale");

endmodule

bind srgb_to_lightness_gray slg_checker u_slg_checker (.*);
